### src/imu_fp_pkg.sv
// ----------------------------------------------------------------------------
// imu_fp_pkg
// shared types, codes and scaling constants of the inertial frame parser
// ----------------------------------------------------------------------------
package imu_fp_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_ACC  = 8'h52;
    localparam logic [7:0] TYPE_GYRO = 8'h51;
    localparam logic [7:0] TYPE_ANG  = 8'h53;

    localparam logic [1:0] KIND_ACC  = 2'd0;
    localparam logic [1:0] KIND_GYRO = 2'd1;
    localparam logic [1:0] KIND_ANG  = 2'd2;

    localparam int WORD_W  = 17;
    localparam int PROD_W  = 32;
    localparam int U_W     = 23;
    localparam int RCP_W   = 29;
    localparam int RCP_SH  = 28;
    localparam int VAL_W   = 20;
    localparam int LANES   = 4;

    // offset keeps the dividend positive for the reciprocal divide
    localparam logic signed [PROD_W-1:0] U_OFFSET = 32'sd4000000;

    localparam logic [RCP_W-1:0] RCP_DIV1  = 29'd268435456;
    localparam logic [RCP_W-1:0] RCP_DIV5  = 29'd53687092;
    localparam logic [RCP_W-1:0] RCP_DIV25 = 29'd10737419;

    localparam logic [U_W-1:0] QOFF_DIV1  = 23'd4000000;
    localparam logic [U_W-1:0] QOFF_DIV5  = 23'd800000;
    localparam logic [U_W-1:0] QOFF_DIV25 = 23'd160000;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_TYPE  = 4'd1,
        PH_P0    = 4'd2,
        PH_P1    = 4'd3,
        PH_P2    = 4'd4,
        PH_P3    = 4'd5,
        PH_P4    = 4'd6,
        PH_P5    = 4'd7,
        PH_P6    = 4'd8,
        PH_P7    = 4'd9,
        PH_CKSUM = 4'd10
    } t_phase;

    function automatic logic [13:0] f_mul(input logic [1:0] kind, input logic is_d);
        logic [13:0] k;
        case (kind)
            KIND_ACC:  k = is_d ? 14'd9638 : 14'd49;
            KIND_GYRO: k = is_d ? 14'd64   : 14'd125;
            default:   k = is_d ? 14'd1    : 14'd45;
        endcase
        return k;
    endfunction

    function automatic logic [26:0] f_add(input logic [1:0] kind, input logic is_d);
        return (is_d && kind == KIND_ACC) ? 27'd119701504 : 27'd0;
    endfunction

    function automatic logic [3:0] f_shift(input logic [1:0] kind, input logic is_d);
        logic [3:0] s;
        case (kind)
            KIND_ACC:  s = is_d ? 4'd9 : 4'd3;
            KIND_GYRO: s = is_d ? 4'd0 : 4'd3;
            default:   s = is_d ? 4'd0 : 4'd5;
        endcase
        return s;
    endfunction

    function automatic logic [RCP_W-1:0] f_recip(input logic [1:0] kind, input logic is_d);
        logic [RCP_W-1:0] r;
        case (kind)
            KIND_ACC:  r = is_d ? RCP_DIV25 : RCP_DIV5;
            KIND_GYRO: r = is_d ? RCP_DIV25 : RCP_DIV1;
            default:   r = RCP_DIV1;
        endcase
        return r;
    endfunction

    function automatic logic [U_W-1:0] f_qoff(input logic [1:0] kind, input logic is_d);
        logic [U_W-1:0] q;
        case (kind)
            KIND_ACC:  q = is_d ? QOFF_DIV25 : QOFF_DIV5;
            KIND_GYRO: q = is_d ? QOFF_DIV25 : QOFF_DIV1;
            default:   q = QOFF_DIV1;
        endcase
        return q;
    endfunction

endpackage

### src/imu_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_frame_parser
// byte-serial parser for 0x55-headed inertial sensor frames, scaled to Q.8
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                              | tuser      | tlast
//  s_axis   | in  | rx_byte                            | -          | chunk_end
//  m_axis   | out | value_a, value_b, value_c, value_d | frame_kind | -
//
//  one byte accepted per cycle unless the pipeline stalls; after the last payload
//  byte, a result passes the word, multiply, reciprocal-divide and output stages
//  reset (synchronous, active low) returns the parser to header hunting and
//  empties the result pipeline
//  a stalled output holds the pipeline; bytes keep flowing while a stage is free
// ----------------------------------------------------------------------------
module imu_frame_parser
    import imu_fp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tlast,   // chunk_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // value_a, value_b, value_c, value_d
    output logic [1:0]  m_axis_tuser    // frame_kind
);

    t_phase     r_phase, n_phase;
    logic [1:0] r_type, n_type;
    logic [7:0] r_pay [0:6];
    logic       w_acc, w_pay_we, w_emit;
    logic [2:0] w_pay_idx;

    logic       r_v1, r_v2, r_v3, r_ov;
    logic       e1, e2, e3, e_o;
    logic [1:0] r_k1, r_k2, r_k3, r_ok;
    logic signed [WORD_W-1:0] r_w [0:LANES-1];
    logic signed [PROD_W-1:0] r_p [0:LANES-1];
    logic [U_W-1:0]           r_q [0:LANES-1];
    logic [VAL_W-1:0]         r_val [0:LANES-1];

    assign e_o = !r_ov || m_axis_tready;
    assign e3  = !r_v3 || e_o;
    assign e2  = !r_v2 || e3;
    assign e1  = !r_v1 || e2;

    assign s_axis_tready = e1;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_pay_idx     = 3'(r_phase - PH_P0);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        case (r_phase) inside
            PH_TYPE: begin
                if (s_axis_tdata == TYPE_ACC) begin
                    n_type  = KIND_ACC;
                    n_phase = PH_P0;
                end else if (s_axis_tdata == TYPE_GYRO) begin
                    n_type  = KIND_GYRO;
                    n_phase = PH_P0;
                end else if (s_axis_tdata == TYPE_ANG) begin
                    n_type  = KIND_ANG;
                    n_phase = PH_P0;
                end else begin
                    n_phase = (s_axis_tdata == HDR_BYTE) ? PH_TYPE : PH_HUNT;
                end
            end
            [PH_P0:PH_P7]: begin
                n_phase = t_phase'(r_phase + 4'd1);
            end
            PH_CKSUM: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = (s_axis_tdata == HDR_BYTE) ? PH_TYPE : PH_HUNT;
            end
        endcase
        if (s_axis_tlast) begin
            n_phase = PH_HUNT;
        end
    end

    // outputs of the phase machine
    always_comb begin
        w_pay_we = 1'b0;
        w_emit   = 1'b0;
        case (r_phase) inside
            [PH_P0:PH_P6]: begin
                w_pay_we = 1'b1;
            end
            PH_P7: begin
                w_emit = 1'b1;
            end
            default: begin
                w_pay_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_type  <= KIND_ACC;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_type  <= n_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_pay_we) begin
            r_pay[w_pay_idx] <= s_axis_tdata;
        end
    end

    // word stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (e1) begin
            r_v1 <= w_acc && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1) begin
            r_k1   <= r_type;
            r_w[0] <= {r_pay[1][7], r_pay[1], r_pay[0]};
            r_w[1] <= {r_pay[3][7], r_pay[3], r_pay[2]};
            r_w[2] <= {r_pay[5][7], r_pay[5], r_pay[4]};
            r_w[3] <= {(r_type != KIND_ANG) && s_axis_tdata[7], s_axis_tdata, r_pay[6]};
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (e2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e2) begin
            r_k2 <= r_k1;
            for (int i = 0; i < LANES; i++) begin
                r_p[i] <= PROD_W'($signed({{(PROD_W-WORD_W){r_w[i][WORD_W-1]}}, r_w[i]})
                          * $signed({18'd0, f_mul(r_k1, i == LANES-1)}))
                          + $signed({5'd0, f_add(r_k1, i == LANES-1)});
            end
        end
    end

    // reciprocal divide stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (e3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [PROD_W-1:0] sum;
        logic [U_W-1:0]           u;
        logic [51:0]              prod;
        if (e3) begin
            r_k3 <= r_k2;
            for (int i = 0; i < LANES; i++) begin
                sum    = (r_p[i] >>> f_shift(r_k2, i == LANES-1)) + U_OFFSET;
                u      = sum[U_W-1:0];
                prod   = 52'(u) * 52'(f_recip(r_k2, i == LANES-1));
                r_q[i] <= prod[RCP_SH+U_W-1:RCP_SH];
            end
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (e_o) begin
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [U_W-1:0] diff;
        if (e_o) begin
            r_ok <= r_k3;
            for (int i = 0; i < LANES; i++) begin
                diff     = r_q[i] - f_qoff(r_k3, i == LANES-1);
                r_val[i] <= diff[VAL_W-1:0];
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_ok;
    assign m_axis_tdata  = {r_val[3], r_val[2], r_val[1], r_val[0]};

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_phase == PH_P7) |=> r_v1)
        else $error("frame end did not reach the word stage");

    a_out_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_ov && r_v3) |=> r_ov)
        else $error("result lost between divide and output stage");

    a_chunk_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && s_axis_tlast) |=> (r_phase == PH_HUNT))
        else $error("parser not hunting after chunk end");

endmodule

### dv/tb_imu_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_imu_frame_parser
// self-checking bench for the 0x55-headed inertial frame parser: bytes stream
// in with random gaps and broken frames, a software parser predicts the scaled
// Q.8 results and a scoreboard compares each output field by field
// ----------------------------------------------------------------------------
module tb_imu_frame_parser;
    import imu_fp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET    = 1850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic [1:0]  kind;
        logic [19:0] val [4];
    } t_imu_result;

    class imu_result_board;
        t_phase      phase;
        logic [1:0]  kind;
        logic [7:0]  payload [8];
        t_imu_result pending_results [$];
        int          mismatch_count;

        function new();
            phase = PH_HUNT;
            kind  = KIND_ACC;
            foreach (payload[i]) payload[i] = 8'h00;
            mismatch_count = 0;
        endfunction

        function longint floor_div(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0) q = q - 1;
            return q;
        endfunction

        function longint word_at(int i);
            logic signed [15:0] ws;
            ws = {payload[2*i+1], payload[2*i]};
            return longint'(ws);
        endfunction

        function t_imu_result scaled_frame();
            t_imu_result r;
            longint      v;
            r.kind = kind;
            for (int i = 0; i < 4; i++) begin
                case (kind)
                    KIND_ACC: begin
                        v = (i == 3) ? floor_div(word_at(i) * 9638 + 119701504, 12800)
                                     : floor_div(word_at(i) * 49, 40);
                    end
                    KIND_GYRO: begin
                        v = (i == 3) ? floor_div(word_at(i) * 64, 25)
                                     : floor_div(word_at(i) * 125, 8);
                    end
                    default: begin
                        v = (i == 3) ? longint'({payload[7], payload[6]})
                                     : floor_div(word_at(i) * 45, 32);
                    end
                endcase
                r.val[i] = v[19:0];
            end
            return r;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            case (phase)
                PH_HUNT: begin
                    phase = (b == HDR_BYTE) ? PH_TYPE : PH_HUNT;
                end
                PH_TYPE: begin
                    if (b == TYPE_ACC) begin
                        kind  = KIND_ACC;
                        phase = PH_P0;
                    end else if (b == TYPE_GYRO) begin
                        kind  = KIND_GYRO;
                        phase = PH_P0;
                    end else if (b == TYPE_ANG) begin
                        kind  = KIND_ANG;
                        phase = PH_P0;
                    end else begin
                        phase = (b == HDR_BYTE) ? PH_TYPE : PH_HUNT;
                    end
                end
                PH_CKSUM: begin
                    phase = PH_HUNT;
                end
                default: begin
                    payload[phase - PH_P0] = b;
                    if (phase == PH_P7) pending_results.push_back(scaled_frame());
                    phase = t_phase'(phase + 1);
                end
            endcase
            if (last) phase = PH_HUNT;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_result(logic [1:0] got_kind, logic [79:0] got_data);
            t_imu_result exp_r;
            string       names [4];
            names = '{"value_a", "value_b", "value_c", "value_d"};
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result kind=%0d data=%h", got_kind, got_data));
            end else begin
                exp_r = pending_results.pop_front();
                if (got_kind !== exp_r.kind)
                    report($sformatf("frame_kind got %0d exp %0d", got_kind, exp_r.kind));
                for (int i = 0; i < 4; i++) begin
                    if (got_data[20*i +: 20] !== exp_r.val[i])
                        report($sformatf("%s got %h exp %h (kind %0d)", names[i],
                                         got_data[20*i +: 20], exp_r.val[i], exp_r.kind));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // rx_byte
    logic        s_axis_tlast;   // chunk_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // value_a, value_b, value_c, value_d
    logic [1:0]  m_axis_tuser;   // frame_kind

    imu_result_board board;
    bit              quiet;
    int              bytes_sent;

    imu_frame_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [15:0] draw_word();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_byte(b, last);
        @(negedge i_clk);
    endtask

    // sends header, type, payload and checksum up to byte index stop
    task automatic send_frame(input logic [7:0] type_byte, input logic [15:0] w0,
                              input logic [15:0] w1, input logic [15:0] w2,
                              input logic [15:0] w3, input int stop, input logic end_flag);
        logic [7:0] frame [11];
        frame[0]  = HDR_BYTE;
        frame[1]  = type_byte;
        {frame[3], frame[2]} = w0;
        {frame[5], frame[4]} = w1;
        {frame[7], frame[6]} = w2;
        {frame[9], frame[8]} = w3;
        frame[10] = 8'($urandom_range(0, 255));
        for (int i = 0; i <= stop; i++) begin
            send_byte(frame[i], (i == stop) ? end_flag : 1'b0);
            bytes_sent++;
        end
    endtask

    task automatic wait_results_done();
        s_axis_tvalid = 1'b0;
        while (board.pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic random_frame();
        logic [7:0] type_byte;
        int         pick;
        int         stop;
        logic       end_flag;
        pick = $urandom_range(0, 2);
        type_byte = (pick == 0) ? TYPE_ACC : (pick == 1) ? TYPE_GYRO : TYPE_ANG;
        stop = 10;
        end_flag = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 15) == 0) begin
            stop = 9;
            end_flag = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
            send_byte(HDR_BYTE, 1'b0);
            bytes_sent++;
        end
        send_frame(type_byte, draw_word(), draw_word(), draw_word(), draw_word(),
                   stop, end_flag);
    endtask

    task automatic broken_frame();
        logic [7:0] type_byte;
        int         pick;
        pick = $urandom_range(0, 3);
        if (pick == 3) begin
            type_byte = ($urandom_range(0, 1) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255));
            send_frame(type_byte, 16'h0, 16'h0, 16'h0, 16'h0, 1, 1'($urandom_range(0, 1)));
        end else begin
            type_byte = (pick == 0) ? TYPE_ACC : (pick == 1) ? TYPE_GYRO : TYPE_ANG;
            send_frame(type_byte, draw_word(), draw_word(), draw_word(), draw_word(),
                       $urandom_range(0, 8), 1'b1);
        end
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            bytes_sent++;
        end
    endtask

    initial begin
        int frames;
        int r;
        board         = new();
        quiet         = 1'b0;
        bytes_sent    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // header repeated in the type slot, chunk end on the last payload byte
        send_byte(HDR_BYTE, 1'b0);
        bytes_sent++;
        send_frame(TYPE_ACC, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h5555, 9, 1'b1);
        // partial frame cut by chunk end
        send_frame(TYPE_ANG, 16'h00FF, 16'h0000, 16'h0000, 16'h0000, 3, 1'b1);
        // unknown type byte
        send_frame(8'h99, 16'h0, 16'h0, 16'h0, 16'h0, 1, 1'b0);
        send_frame(TYPE_GYRO, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 10, 1'b0);
        send_frame(TYPE_ANG, 16'h7FFF, 16'h8000, 16'h55AA, 16'hFFFF, 10, 1'b1);

        frames = 0;
        while (bytes_sent < BYTE_TARGET) begin
            quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 75) random_frame();
            else if (r < 87) broken_frame();
            else noise_burst();
            frames++;
            if (frames == 60 || $urandom_range(0, 49) == 0) wait_results_done();
        end

        s_axis_tvalid = 1'b0;
        quiet = 1'b0;
        wait_results_done();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (board.mismatch_count == 0 && board.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check_result(m_axis_tuser, m_axis_tdata);
            @(negedge i_clk);
        end
    end

    // no handshake on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] watchdog expired", $realtime);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
